// ===== hdl/bad_pkg.sv =====
// ----------------------------------------------------------------------------
// bad_pkg
// Shared widths, constants and structs of the box-average downscaler.
// ----------------------------------------------------------------------------
package bad_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int CFG_W = 13;
	localparam int SUM_W = 32;
	localparam int CNT_W = 25;
	localparam int PIX_W = 8;
	localparam int POS_W = 12;
	// running products (index + 1) * size stay below 2^25
	localparam int ACC_W = 26;

	localparam logic [1:0] REG_SOURCE_WIDTH = 2'd0;
	localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TARGET_WIDTH = 2'd2;
	localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] blue;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] red;
	} bad_entry_t;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] addr;
		bad_entry_t data;
	} bad_mem_wr_t;

	typedef struct packed {
		logic start;
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
		logic [CNT_W-1:0] count;
	} bad_div_req_t;

	typedef struct packed {
		logic done;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} bad_div_rsp_t;

endpackage

// ===== hdl/box_average_downscale.sv =====
// ----------------------------------------------------------------------------
// box_average_downscale
// Area-average image downscaler: accumulates source pixels per output column
// and emits each box average when its last pixel arrives.
//
//   port group   dir  payload
//   s_axis_*     in   source pixel, raster order
//   m_axis_*     out  averaged pixel with position, tlast on last of frame
//   cfg_*        in   register writes (sizes), any write restarts the frame
//
// An item is accepted, then its column entry is read, modified and written
// back through the registered-read memory; an item that closes a box then
// also runs through the bit-serial divider.
// After reset and after every register write a clearing pass zeroes all
// MAX_WIDTH (4096) entries of the column store; no pixel is taken meanwhile.
// A finished result waits in the output register while the next pixel is
// taken; the divider holds if that register is still full.
// ----------------------------------------------------------------------------
module box_average_downscale import bad_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [23:0] s_axis_tdata, // red_in, green_in, blue_in
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [47:0] m_axis_tdata, // red_out, green_out, blue_out, out_column, out_row
	output logic m_axis_tlast, // frame_done
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	localparam logic [1:0] S_CLR = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_RMW = 2'd2;
	localparam logic [1:0] S_DIV = 2'd3;

	localparam logic [CFG_W-1:0] MAX_W_C = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] MAX_H_C = CFG_W'(MAX_HEIGHT);

	logic [1:0] state_q;
	logic [CFG_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic [CFG_W-1:0] sw, sh, tw, th;
	logic [ADDR_W:0] clr_cnt_q;

	logic [POS_W-1:0] scol_q, srow_q, ocol_q, orow_q;
	logic [ACC_W-1:0] col_a_q, col_b_q, row_a_q, row_b_q;
	logic col_last, row_last, accept;

	logic [PIX_W-1:0] pix_q [3];
	logic emit_q, fdone_q;
	logic [POS_W-1:0] epos_col_q, epos_row_q;
	logic [ADDR_W-1:0] addr_q;

	bad_mem_wr_t mem_wr;
	bad_entry_t rd_data, upd;
	bad_div_req_t div_req;
	bad_div_rsp_t div_rsp;

	logic m_valid_q;
	logic [47:0] m_data_q;
	logic m_last_q;
	logic out_free;
	logic out_load;

	// effective sizes
	always_comb begin
		sw = (src_w_q == '0) ? CFG_W'(1) : ((src_w_q > MAX_W_C) ? MAX_W_C : src_w_q);
		sh = (src_h_q == '0) ? CFG_W'(1) : ((src_h_q > MAX_H_C) ? MAX_H_C : src_h_q);
		tw = (tgt_w_q == '0) ? CFG_W'(1) : ((tgt_w_q > sw) ? sw : tgt_w_q);
		th = (tgt_h_q == '0) ? CFG_W'(1) : ((tgt_h_q > sh) ? sh : tgt_h_q);
	end

	// source index c ends box w when (c+1)*t <= (w+1)*s < (c+2)*t
	assign col_last = (col_b_q <= col_a_q) && (col_a_q < col_b_q + ACC_W'(tw));
	assign row_last = (row_b_q <= row_a_q) && (row_a_q < row_b_q + ACC_W'(th));

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = (state_q == S_DIV) && div_rsp.done && out_free && !cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= CFG_W'(1);
			src_h_q <= CFG_W'(1);
			tgt_w_q <= CFG_W'(1);
			tgt_h_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH: src_w_q <= cfg_data;
				REG_SOURCE_HEIGHT: src_h_q <= cfg_data;
				REG_TARGET_WIDTH: tgt_w_q <= cfg_data;
				REG_TARGET_HEIGHT: tgt_h_q <= cfg_data;
				default: src_w_q <= src_w_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_cnt_q <= '0;
			scol_q <= '0;
			srow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			col_a_q <= '0;
			col_b_q <= '0;
			row_a_q <= '0;
			row_b_q <= '0;
			emit_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				state_q <= S_CLR;
				clr_cnt_q <= '0;
			end else begin
				unique case (state_q)
					S_CLR: begin
						// hold the position state at frame start while sweeping
						scol_q <= '0;
						srow_q <= '0;
						ocol_q <= '0;
						orow_q <= '0;
						col_a_q <= ACC_W'(sw);
						col_b_q <= ACC_W'(tw);
						row_a_q <= ACC_W'(sh);
						row_b_q <= ACC_W'(th);
						clr_cnt_q <= clr_cnt_q + 1'b1;
						if (clr_cnt_q == (ADDR_W+1)'(MAX_WIDTH - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (accept) begin
							state_q <= S_RMW;
							emit_q <= col_last && row_last;
							if ({1'b0, scol_q} + 1'b1 >= sw) begin
								scol_q <= '0;
								ocol_q <= '0;
								col_a_q <= ACC_W'(sw);
								col_b_q <= ACC_W'(tw);
								if ({1'b0, srow_q} + 1'b1 >= sh) begin
									srow_q <= '0;
									orow_q <= '0;
									row_a_q <= ACC_W'(sh);
									row_b_q <= ACC_W'(th);
								end else begin
									srow_q <= srow_q + 1'b1;
									row_b_q <= row_b_q + ACC_W'(th);
									if (row_last && ({1'b0, orow_q} + 1'b1 < th)) begin
										orow_q <= orow_q + 1'b1;
										row_a_q <= row_a_q + ACC_W'(sh);
									end
								end
							end else begin
								scol_q <= scol_q + 1'b1;
								col_b_q <= col_b_q + ACC_W'(tw);
								if (col_last && ({1'b0, ocol_q} + 1'b1 < tw)) begin
									ocol_q <= ocol_q + 1'b1;
									col_a_q <= col_a_q + ACC_W'(sw);
								end
							end
						end
					end
					S_RMW: begin
						state_q <= emit_q ? S_DIV : S_IDLE;
					end
					S_DIV: begin
						if (div_rsp.done && out_free) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_CLR;
				endcase
			end
		end
	end

	// beat payload and emit details, captured at accept; output beat on divider done
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q[0] <= s_axis_tdata[7:0];
			pix_q[1] <= s_axis_tdata[15:8];
			pix_q[2] <= s_axis_tdata[23:16];
			addr_q <= ocol_q;
			epos_col_q <= ocol_q;
			epos_row_q <= orow_q;
			fdone_q <= ({1'b0, ocol_q} + 1'b1 == tw) && ({1'b0, orow_q} + 1'b1 == th);
		end
		if (state_q == S_DIV && div_rsp.done && out_free) begin
			m_data_q <= {epos_row_q, epos_col_q, div_rsp.blue, div_rsp.green, div_rsp.red};
			m_last_q <= fdone_q;
		end
	end

	always_comb begin
		upd.red = rd_data.red + SUM_W'(pix_q[0]);
		upd.green = rd_data.green + SUM_W'(pix_q[1]);
		upd.blue = rd_data.blue + SUM_W'(pix_q[2]);
		upd.count = rd_data.count + 1'b1;

		mem_wr.we = 1'b0;
		mem_wr.addr = addr_q;
		mem_wr.data = upd;
		if (state_q == S_CLR) begin
			mem_wr.we = 1'b1;
			mem_wr.addr = clr_cnt_q[ADDR_W-1:0];
			mem_wr.data = '0;
		end else if (state_q == S_RMW) begin
			mem_wr.we = 1'b1;
			// drop the column's sums once its box is closed
			if (emit_q) begin
				mem_wr.data = '0;
			end
		end

		div_req.start = (state_q == S_RMW) && emit_q;
		div_req.red = upd.red;
		div_req.green = upd.green;
		div_req.blue = upd.blue;
		div_req.count = upd.count;
	end

	bad_sum_mem u_mem (
		.clk(clk),
		.wr(mem_wr),
		.rd_en(accept),
		.rd_addr(ocol_q),
		.rd_data(rd_data)
	);

	bad_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tlast = m_last_q;

endmodule

// ===== hdl/bad_sum_mem.sv =====
// ----------------------------------------------------------------------------
// bad_sum_mem
// Column accumulator store: per output column the three channel sums and the
// pixel count. One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bad_sum_mem import bad_pkg::*; (
	input logic clk,
	input bad_mem_wr_t wr,
	input logic rd_en,
	input logic [ADDR_W-1:0] rd_addr,
	output bad_entry_t rd_data
);

	bad_entry_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/bad_divider.sv =====
// ----------------------------------------------------------------------------
// bad_divider
// Restoring divider for the three channel averages. The quotient never
// exceeds eight bits, so eight steps, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bad_divider import bad_pkg::*; (
	input logic clk,
	input logic arst_n,
	input bad_div_req_t req,
	output bad_div_rsp_t rsp
);

	logic [SUM_W-1:0] rem_q [3];
	logic [PIX_W-1:0] quo_q [3];
	logic [SUM_W-1:0] dvs_q;
	logic [2:0] step_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd7) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q[0] <= req.red;
			rem_q[1] <= req.green;
			rem_q[2] <= req.blue;
			// divisor starts aligned to the top quotient bit
			dvs_q <= {req.count, 7'd0};
		end else if (busy_q) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (rem_q[ch] >= dvs_q) begin
					rem_q[ch] <= rem_q[ch] - dvs_q;
					quo_q[ch] <= {quo_q[ch][PIX_W-2:0], 1'b1};
				end else begin
					quo_q[ch] <= {quo_q[ch][PIX_W-2:0], 1'b0};
				end
			end
			dvs_q <= dvs_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.red = quo_q[0];
	assign rsp.green = quo_q[1];
	assign rsp.blue = quo_q[2];

endmodule

// ===== verif/box_average_downscale_checker.sv =====
// ----------------------------------------------------------------------------
// box_average_downscale_checker
// Watches the pixel, result and register channels of the downscaler, keeps
// its own copy of the column sums and box edges, predicts each averaged
// pixel and compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
module box_average_downscale_checker import bad_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_valid,
	input logic s_ready,
	input logic [23:0] s_data,
	input logic m_valid,
	input logic m_ready,
	input logic [47:0] m_data,
	input logic m_last,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	output int pending,
	output int errors
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic done;
	} avg_pixel_t;

	avg_pixel_t avg_pixel_q[$];
	logic [CFG_W-1:0] size_reg[4];
	logic [SUM_W-1:0] red_acc[MAX_WIDTH];
	logic [SUM_W-1:0] green_acc[MAX_WIDTH];
	logic [SUM_W-1:0] blue_acc[MAX_WIDTH];
	logic [CNT_W-1:0] pix_cnt[MAX_WIDTH];
	int unsigned src_col, src_row, dst_col, dst_row, col_bound, row_bound;

	initial errors = 0;
	initial pending = 0;

	function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned box_bound(int unsigned k, int unsigned from,
			int unsigned to);
		longint unsigned p;
		p = longint'(k) * from;
		return int'(p / to);
	endfunction

	function automatic void sizes(output int unsigned sw, sh, tw, th);
		sw = clamp_size(size_reg[REG_SOURCE_WIDTH], MAX_WIDTH);
		sh = clamp_size(size_reg[REG_SOURCE_HEIGHT], MAX_HEIGHT);
		tw = clamp_size(size_reg[REG_TARGET_WIDTH], sw);
		th = clamp_size(size_reg[REG_TARGET_HEIGHT], sh);
	endfunction

	function automatic void restart_frame();
		int unsigned sw, sh, tw, th;
		sizes(sw, sh, tw, th);
		for (int i = 0; i < MAX_WIDTH; i++) begin
			red_acc[i] = '0;
			green_acc[i] = '0;
			blue_acc[i] = '0;
			pix_cnt[i] = '0;
		end
		src_col = 0;
		src_row = 0;
		dst_col = 0;
		dst_row = 0;
		col_bound = box_bound(1, sw, tw);
		row_bound = box_bound(1, sh, th);
	endfunction

	function automatic void accumulate(logic [23:0] px);
		int unsigned sw, sh, tw, th, c;
		logic col_end, row_end;
		logic [CNT_W-1:0] n;
		avg_pixel_t a;
		sizes(sw, sh, tw, th);
		c = dst_col;
		red_acc[c] += px[7:0];
		green_acc[c] += px[15:8];
		blue_acc[c] += px[23:16];
		pix_cnt[c] += 1'b1;
		col_end = (src_col + 1 == col_bound);
		row_end = (src_row + 1 == row_bound);
		if (col_end && row_end) begin
			n = (pix_cnt[c] != 0) ? pix_cnt[c] : 1;
			a.red = PIX_W'(red_acc[c] / n);
			a.green = PIX_W'(green_acc[c] / n);
			a.blue = PIX_W'(blue_acc[c] / n);
			a.column = POS_W'(dst_col);
			a.row = POS_W'(dst_row);
			a.done = (dst_col + 1 == tw) && (dst_row + 1 == th);
			avg_pixel_q.push_back(a);
			red_acc[c] = '0;
			green_acc[c] = '0;
			blue_acc[c] = '0;
			pix_cnt[c] = '0;
		end
		// advance raster position and box edges
		if (src_col + 1 >= sw) begin
			src_col = 0;
			dst_col = 0;
			col_bound = box_bound(1, sw, tw);
			if (src_row + 1 >= sh) begin
				src_row = 0;
				dst_row = 0;
				row_bound = box_bound(1, sh, th);
			end else begin
				src_row++;
				if (row_end && dst_row + 1 < th) begin
					dst_row++;
					row_bound = box_bound(dst_row + 1, sh, th);
				end
			end
		end else begin
			src_col++;
			if (col_end && dst_col + 1 < tw) begin
				dst_col++;
				col_bound = box_bound(dst_col + 1, sw, tw);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		avg_pixel_t w, g;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) size_reg[i] = 1;
			restart_frame();
			avg_pixel_q.delete();
		end else begin
			if (cfg_we) begin
				size_reg[cfg_index] = cfg_data;
				restart_frame();
			end
			if (s_valid && s_ready) accumulate(s_data);
			if (m_valid && m_ready) begin
				g = {m_data[7:0], m_data[15:8], m_data[23:16], m_data[35:24],
					m_data[47:36], m_last};
				if (avg_pixel_q.size() == 0) begin
					$display("%0t: unexpected beat, got %h", $time, g);
					errors++;
				end else begin
					w = avg_pixel_q.pop_front();
					if (w !== g) begin
						$display("%0t: mismatch, expected r%0d g%0d b%0d c%0d r%0d l%0d, got r%0d g%0d b%0d c%0d r%0d l%0d",
							$time, w.red, w.green, w.blue, w.column, w.row, w.done,
							g.red, g.green, g.blue, g.column, g.row, g.done);
						errors++;
					end
				end
			end
		end
		pending = avg_pixel_q.size();
	end

endmodule

// ===== verif/box_average_downscale_tb.sv =====
// ----------------------------------------------------------------------------
// box_average_downscale_tb
// Drives frames of random pixels through the downscaler under a series of
// size settings, with random stalls on both streams, and lets the checker
// judge every averaged pixel.
// ----------------------------------------------------------------------------
module box_average_downscale_tb import bad_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 30000;
	localparam int SETTLE = 40;

	logic clk = 0;
	logic arst_n = 0;
	logic s_valid = 0;
	logic s_ready;
	logic [23:0] s_data = '0; // red_in, green_in, blue_in
	logic m_valid;
	logic m_ready = 0;
	logic [47:0] m_data; // red_out, green_out, blue_out, out_column, out_row
	logic m_last; // frame_done
	logic cfg_we = 0;
	logic [1:0] cfg_index = REG_SOURCE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	int pending, errors;
	int pixels_sent = 0;
	int tx_idle = 12, rx_idle = 88;
	bit hold_req = 0, hold_seen = 0;
	int hold_left = 0, quiet = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	box_average_downscale i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
		.m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
		.m_axis_tlast(m_last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	box_average_downscale_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
		.m_valid(m_valid), .m_ready(m_ready), .m_data(m_data), .m_last(m_last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .errors(errors)
	);

	// result side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_seen) begin
			hold_seen = 1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_ready <= 0;
		end else begin
			m_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_valid && s_ready) || (m_valid && m_ready) || !arst_n) quiet = 0;
		else quiet++;
		if (quiet >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic put_pixel(input logic [23:0] px);
		if (pixels_sent >= 400) begin
			tx_idle = 0;
			rx_idle = 0;
		end else if (pixels_sent >= 200) begin
			tx_idle = 88;
			rx_idle = 12;
		end
		while ($urandom_range(99) < tx_idle) begin
			s_valid <= 0;
			@(posedge clk);
		end
		s_valid <= 1;
		s_data <= px;
		do @(posedge clk); while (!s_ready);
		pixels_sent++;
	endtask

	task automatic drain();
		s_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(v);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_sizes(input int unsigned sw, sh, tw, th);
		drain();
		write_reg(REG_SOURCE_WIDTH, sw);
		write_reg(REG_SOURCE_HEIGHT, sh);
		write_reg(REG_TARGET_WIDTH, tw);
		write_reg(REG_TARGET_HEIGHT, th);
	endtask

	task automatic put_random(input int n);
		for (int i = 0; i < n; i++) put_pixel(24'($urandom));
	endtask

	initial begin
		int unsigned sw, sh, tw, th, frames, n;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		// reset sizes: every pixel is a box; hold the result side off meanwhile
		hold_req = 1;
		put_pixel(24'h000000);
		put_pixel(24'hFFFFFF);
		put_pixel(24'hFF00FF);
		put_random(30);
		// zero sizes count as one
		set_sizes(0, 0, 0, 0);
		put_pixel(24'hFFFFFF);
		put_random(2);
		// oversized source and target, frame cut short by the next write
		set_sizes(8191, 2, 8191, 1);
		put_random(10);
		// upscale request saturates to the source size
		set_sizes(4, 4, 8, 8);
		put_random(16);
		// uneven boxes, all-max pixels for the sum path
		set_sizes(5, 3, 2, 2);
		repeat (15) put_pixel(24'hFFFFFF);
		while (pixels_sent < 600) begin
			sw = $urandom_range(1, 12);
			sh = $urandom_range(1, 8);
			tw = $urandom_range(0, sw + 2);
			th = $urandom_range(0, sh + 2);
			if ($urandom_range(9) == 0) sw = 0;
			set_sizes(sw, sh, tw, th);
			if (sw == 0) sw = 1;
			frames = $urandom_range(1, 2);
			n = frames * sw * sh;
			// occasionally break off mid-frame
			if ($urandom_range(7) == 0) n = $urandom_range(1, n);
			put_random(n);
		end
		drain();
		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
